// ===== rtl/stkc_pkg.sv =====
package stkc_pkg;

	typedef enum logic [3:0] {
		CMD_PUSH  = 4'd0,
		CMD_PUSHV = 4'd1,
		CMD_POP   = 4'd2,
		CMD_STORE = 4'd3,
		CMD_ABS   = 4'd4,
		CMD_PLUS  = 4'd5,
		CMD_MINUS = 4'd6,
		CMD_MUL   = 4'd7,
		CMD_DIV   = 4'd8,
		CMD_PRINT = 4'd9
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_EMPTY = 3'd1,
		ST_FEW   = 3'd2,
		ST_UNSET = 3'd3,
		ST_OVF   = 3'd4,
		ST_DIV0  = 3'd5,
		ST_FULL  = 3'd6
	} status_t;

	localparam int unsigned DW = 64;

	// handshake between the sequencer and the magnitude multiply/divide unit
	typedef struct packed {
		logic start;
		logic is_div;
	} mdu_req_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} mdu_rsp_t;

endpackage

// ===== rtl/stkc_ram.sv =====
module stkc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/stkc_mdu.sv =====
// Unsigned 64-bit magnitude multiply and divide, one bit per cycle.
// Multiply flags a product of 2^64 or more; the caller checks the sign range.
module stkc_mdu
	import stkc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  mdu_req_t      req,
	input  logic [DW-1:0] a,
	input  logic [DW-1:0] b,
	output mdu_rsp_t      rsp,
	output logic [DW-1:0] result
);

	logic          busy_q;
	logic          div_q;
	logic [6:0]    cnt_q;
	logic [DW-1:0] acc_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] opa_q;
	logic [DW-1:0] opb_q;
	logic          ovf_q;
	logic          done_q;

	logic [DW:0]   rem_sh;
	logic [DW:0]   rem_sub;
	logic [DW:0]   mul_sh;
	logic [DW:0]   mul_add;

	always_comb begin
		rem_sh  = {rem_q, acc_q[DW-1]};
		rem_sub = rem_sh - {1'b0, opb_q};
		mul_sh  = {acc_q, 1'b0};
		mul_add = mul_sh + (opa_q[DW-1] ? {1'b0, opb_q} : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q <= req.is_div;
			opb_q <= b;
			ovf_q <= 1'b0;
			rem_q <= '0;
			if (req.is_div) begin
				acc_q <= a;
				opa_q <= a;
			end else begin
				acc_q <= '0;
				opa_q <= a;
			end
		end else if (busy_q) begin
			if (div_q) begin
				// restoring division: quotient bits shift into acc
				if (!rem_sub[DW]) begin
					rem_q <= rem_sub[DW-1:0];
					acc_q <= {acc_q[DW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[DW-1:0];
					acc_q <= {acc_q[DW-2:0], 1'b0};
				end
			end else begin
				// shift-add, multiplier bits from the top
				if (acc_q[DW-1] || mul_add[DW])
					ovf_q <= 1'b1;
				acc_q <= mul_add[DW-1:0];
				opa_q <= {opa_q[DW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.ovf  = ovf_q;
	assign result   = acc_q;

endmodule

// ===== rtl/stack_calculator_core.sv =====
// Channel | Dir | tdata (low bit up)                          | tuser
// s_axis  | in  | cmd[3:0], operand_value[67:4], var_index[71:68] | -
// m_axis  | out | status[2:0], top_value[66:3], printed[67]    | -
// Every command passes through two stack reads, execute and write back, top-of-stack
// read and output load on its way from the s_axis transfer to m_axis_tvalid.
// MUL and DIV add a wait in the bit-serial multiply/divide unit after execute.
// s_axis_tready returns in the cycle after the output load.
// arst_n clears the stack count and the variable valid marks; memories keep data.
// One command at a time; a result held by m_axis_tready low keeps s_axis_tready low
// only until the result register can be reloaded.
module stack_calculator_core
	import stkc_pkg::*;
#(
	parameter int STACK_DEPTH = 64,
	parameter int NUM_VARS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // cmd, operand_value, var_index
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata   // status, top_value, printed, zero pad
);

	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int CW  = $clog2(STACK_DEPTH + 1);
	localparam int VAW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_RD1   = 7'b0000010,
		S_RD2   = 7'b0000100,
		S_EXEC  = 7'b0001000,
		S_MDU   = 7'b0010000,
		S_TOP   = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t         state_q;
	logic [3:0]     cmd_q;
	logic [DW-1:0]  val_q;
	logic [3:0]     vi_q;
	logic [CW-1:0]  cnt_q;
	logic [NUM_VARS-1:0] vvalid_q;
	logic [DW-1:0]  y_q;     // top entry
	logic [DW-1:0]  x_q;     // second entry or variable
	logic [DW-1:0]  x_v;
	logic [DW-1:0]  top_q;
	logic [2:0]     status_q;
	logic           printed_q;
	logic [2:0]     ostatus_q;
	logic           oprinted_q;
	logic           ovalid_q;
	logic           out_load;

	logic           s_we;
	logic [SAW-1:0] s_waddr, s_raddr;
	logic [DW-1:0]  s_wdata, s_rdata;
	logic           v_we;
	logic [VAW-1:0] v_addr;
	logic [DW-1:0]  v_rdata;

	mdu_req_t       mreq;
	mdu_rsp_t       mrsp;
	logic [DW-1:0]  mres;

	logic           vi_ok;
	logic [DW-1:0]  mx, my;
	logic           neg;
	logic [DW-1:0]  sum, dif;

	// second operand comes straight from the memories during execute
	assign x_v    = (state_q == S_EXEC) ? ((cmd_q == CMD_PUSHV) ? v_rdata : s_rdata) : x_q;
	assign vi_ok  = ({28'd0, vi_q} < 32'(NUM_VARS));
	assign v_addr = VAW'(vi_q);
	assign mx     = x_v[DW-1] ? (~x_v + 1'b1) : x_v;
	assign my     = y_q[DW-1] ? (~y_q + 1'b1) : y_q;
	assign neg    = x_v[DW-1] ^ y_q[DW-1];
	assign sum    = x_v + y_q;
	assign dif    = x_v - y_q;

	stkc_ram #(.WIDTH(DW), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	stkc_ram #(.WIDTH(DW), .DEPTH(NUM_VARS)) u_vars (
		.clk(clk), .we(v_we), .waddr(v_addr), .wdata(y_q),
		.raddr(v_addr), .rdata(v_rdata)
	);

	stkc_mdu u_mdu (
		.clk(clk), .arst_n(arst_n), .req(mreq), .a(mx), .b(my),
		.rsp(mrsp), .result(mres)
	);

	assign out_load      = (state_q == S_OUT) && (!ovalid_q || m_axis_tready);
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {4'd0, oprinted_q, top_q, ostatus_q};

	// read address: top in RD1/TOP, second in RD2
	always_comb begin
		s_raddr = SAW'(cnt_q - CW'(1));
		if (state_q == S_RD2)
			s_raddr = SAW'(cnt_q - CW'(2));
	end

	// execute: decide status and the write-back
	logic [2:0]    ex_st;
	logic          ex_wr;
	logic [SAW-1:0] ex_addr;
	logic [DW-1:0] ex_data;
	logic [CW-1:0] ex_cnt;
	logic          ex_vwr;
	logic          ex_mdu;
	logic          ex_print;

	always_comb begin
		ex_st    = ST_OK;
		ex_wr    = 1'b0;
		ex_addr  = SAW'(cnt_q);
		ex_data  = val_q;
		ex_cnt   = cnt_q;
		ex_vwr   = 1'b0;
		ex_mdu   = 1'b0;
		ex_print = 1'b0;
		case (cmd_q)
			CMD_PUSH, CMD_PUSHV: begin
				if (cmd_q == CMD_PUSHV && (!vi_ok || !vvalid_q[v_addr]))
					ex_st = ST_UNSET;
				else if (cnt_q == CW'(STACK_DEPTH))
					ex_st = ST_FULL;
				else begin
					ex_wr   = 1'b1;
					ex_data = (cmd_q == CMD_PUSHV) ? x_v : val_q;
					ex_cnt  = cnt_q + CW'(1);
				end
			end
			CMD_POP: begin
				if (cnt_q == '0) ex_st = ST_EMPTY;
				else ex_cnt = cnt_q - CW'(1);
			end
			CMD_STORE: begin
				if (cnt_q == '0) ex_st = ST_EMPTY;
				else ex_vwr = vi_ok;
			end
			CMD_ABS: begin
				if (cnt_q == '0) ex_st = ST_EMPTY;
				else if (y_q == {1'b1, {(DW-1){1'b0}}}) ex_st = ST_OVF;
				else begin
					ex_wr   = 1'b1;
					ex_addr = SAW'(cnt_q - CW'(1));
					ex_data = my;
				end
			end
			CMD_PLUS, CMD_MINUS, CMD_MUL, CMD_DIV: begin
				ex_addr = SAW'(cnt_q - CW'(2));
				if (cnt_q < CW'(2)) ex_st = ST_FEW;
				else if (cmd_q == CMD_DIV && y_q == '0) ex_st = ST_DIV0;
				else if (cmd_q == CMD_MUL || cmd_q == CMD_DIV) ex_mdu = 1'b1;
				else if (cmd_q == CMD_PLUS) begin
					if ((x_v[DW-1] == y_q[DW-1]) && (sum[DW-1] != x_v[DW-1]))
						ex_st = ST_OVF;
					else begin
						ex_wr = 1'b1; ex_data = sum; ex_cnt = cnt_q - CW'(1);
					end
				end else begin
					if ((x_v[DW-1] != y_q[DW-1]) && (dif[DW-1] != x_v[DW-1]))
						ex_st = ST_OVF;
					else begin
						ex_wr = 1'b1; ex_data = dif; ex_cnt = cnt_q - CW'(1);
					end
				end
			end
			CMD_PRINT: begin
				if (cnt_q == '0) ex_st = ST_EMPTY;
				else ex_print = 1'b1;
			end
			default: ;
		endcase
	end

	// sign the unsigned product or quotient
	logic          md_ovf;
	logic [DW-1:0] md_val;
	always_comb begin
		md_val = neg ? (~mres + 1'b1) : mres;
		if (mrsp.ovf)
			md_ovf = 1'b1;
		else if (neg)
			md_ovf = mres > {1'b1, {(DW-1){1'b0}}};
		else
			md_ovf = mres[DW-1];
	end

	always_comb begin
		s_we    = 1'b0;
		s_waddr = ex_addr;
		s_wdata = ex_data;
		v_we    = 1'b0;
		mreq.start  = 1'b0;
		mreq.is_div = (cmd_q == CMD_DIV);
		if (state_q == S_EXEC) begin
			s_we       = ex_wr;
			v_we       = ex_vwr;
			mreq.start = ex_mdu;
		end else if (state_q == S_MDU && mrsp.done && !md_ovf) begin
			s_we    = 1'b1;
			s_waddr = SAW'(cnt_q - CW'(2));
			s_wdata = md_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			vvalid_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (out_load)
				ovalid_q <= 1'b1;
			else if (m_axis_tvalid && m_axis_tready)
				ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (s_axis_tvalid && s_axis_tready) state_q <= S_RD1;
				S_RD1:  state_q <= S_RD2;
				S_RD2:  state_q <= S_EXEC;
				S_EXEC: begin
					cnt_q <= ex_cnt;
					if (ex_vwr) vvalid_q[v_addr] <= 1'b1;
					state_q <= ex_mdu ? S_MDU : S_TOP;
				end
				S_MDU: if (mrsp.done) begin
					if (!md_ovf) cnt_q <= cnt_q - CW'(1);
					state_q <= S_TOP;
				end
				S_TOP: state_q <= S_OUT;
				// hold until the result register is free
				S_OUT: if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q <= s_axis_tdata[3:0];
				val_q <= s_axis_tdata[67:4];
				vi_q  <= s_axis_tdata[71:68];
			end
			S_RD2: y_q <= s_rdata;
			S_EXEC: begin
				x_q       <= x_v;
				status_q  <= ex_st;
				printed_q <= ex_print;
			end
			S_MDU: if (mrsp.done && md_ovf) status_q <= ST_OVF;
			S_OUT: if (out_load) begin
				top_q      <= (cnt_q == '0) ? '0 : s_rdata;
				ostatus_q  <= status_q;
				oprinted_q <= printed_q;
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/stkc_checker.sv =====
module stkc_checker
	import stkc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [71:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [71:0] m_axis_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped while stalled");

	a_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> (!s_axis_tready) [*4])
		else $error("command taken before previous one finished");

	a_print_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[67] |-> m_axis_tdata[2:0] == ST_OK)
		else $error("print flagged with error status");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[2:0] <= ST_FULL && m_axis_tdata[71:68] == 4'd0)
		else $error("bad status or padding");

endmodule

bind stack_calculator_core stkc_checker u_stkc_checker (.*);
